// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/malu_pkg.sv -----
// ----------------------------------------------------------------------------
// MIPS ALU package
// Operation codes and instruction field encodings shared by the ALU modules.
// ----------------------------------------------------------------------------
`default_nettype none

package malu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OPCODE_W = 6;
    localparam int unsigned FUNCT_W  = 6;

    typedef logic [OPCODE_W-1:0]      opcode_t;
    typedef logic [FUNCT_W-1:0]       funct_t;
    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [3:0] {
        ALU_NONE = 4'd0,
        ALU_ADD  = 4'd1,
        ALU_SUB  = 4'd2,
        ALU_AND  = 4'd3,
        ALU_OR   = 4'd4,
        ALU_XOR  = 4'd5,
        ALU_NOR  = 4'd6,
        ALU_NAND = 4'd7,
        ALU_SLT  = 4'd8,
        ALU_SLL  = 4'd9,
        ALU_SRL  = 4'd10,
        ALU_SRA  = 4'd11,
        ALU_LUI  = 4'd12,
        ALU_ANDI = 4'd13,
        ALU_ORI  = 4'd14,
        ALU_NORI = 4'd15
    } alu_op_t;

    // Opcodes
    localparam opcode_t OPC_RTYPE = 6'h00;
    localparam opcode_t OPC_ADDI  = 6'h08;
    localparam opcode_t OPC_SLTI  = 6'h0A;
    localparam opcode_t OPC_ANDI  = 6'h0C;
    localparam opcode_t OPC_ORI   = 6'h0D;
    localparam opcode_t OPC_NORI  = 6'h0E;
    localparam opcode_t OPC_LUI   = 6'h0F;
    localparam opcode_t OPC_LB    = 6'h20;
    localparam opcode_t OPC_LH    = 6'h21;
    localparam opcode_t OPC_LW    = 6'h23;
    localparam opcode_t OPC_LBU   = 6'h24;
    localparam opcode_t OPC_LHU   = 6'h25;
    localparam opcode_t OPC_SB    = 6'h28;
    localparam opcode_t OPC_SH    = 6'h29;
    localparam opcode_t OPC_SW    = 6'h2B;

    // R-type function codes
    localparam funct_t FN_SLL  = 6'h00;
    localparam funct_t FN_SRL  = 6'h02;
    localparam funct_t FN_SRA  = 6'h03;
    localparam funct_t FN_ADD  = 6'h20;
    localparam funct_t FN_SUB  = 6'h22;
    localparam funct_t FN_AND  = 6'h24;
    localparam funct_t FN_OR   = 6'h25;
    localparam funct_t FN_XOR  = 6'h26;
    localparam funct_t FN_NOR  = 6'h27;
    localparam funct_t FN_NAND = 6'h28;
    localparam funct_t FN_SLT  = 6'h2A;

    // Shift amount position in operand b
    localparam int unsigned SHAMT_LSB = 6;
    localparam int unsigned SHAMT_W   = 5;
    localparam int unsigned IMM_W     = 16;

endpackage

`default_nettype wire

// ----- rtl/malu_if.sv -----
// ----------------------------------------------------------------------------
// MIPS ALU channel interfaces
// Valid/ready channels for the instruction items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface malu_req_if;
    logic               valid;
    logic               ready;
    malu_pkg::opcode_t  opcode;
    malu_pkg::funct_t   funct;
    malu_pkg::word_t    operand_a;
    malu_pkg::word_t    operand_b;

    modport source (output valid, output opcode, output funct,
                    output operand_a, output operand_b, input ready);
    modport sink   (input valid, input opcode, input funct,
                    input operand_a, input operand_b, output ready);
endinterface

interface malu_rsp_if;
    logic               valid;
    logic               ready;
    malu_pkg::word_t    result;
    logic               overflow;
    logic [3:0]         alu_operation;

    modport source (output valid, output result, output overflow,
                    output alu_operation, input ready);
    modport sink   (input valid, input result, input overflow,
                    input alu_operation, output ready);
endinterface

`default_nettype wire

// ----- rtl/mips_alu_with_decode.sv -----
// ----------------------------------------------------------------------------
// MIPS ALU with decode
// Execute-stage ALU that decodes opcode and funct itself and returns the
// result, the signed overflow flag and the decoded operation code.
// ----------------------------------------------------------------------------
// The block takes one instruction item per clock cycle while its output is not
// stalled and returns exactly one result item for each, in order. An accepted
// item is held in an input register; in the following cycle the decoder and
// the datapath work on it in a single pass, and the outcome is written to the
// output register once that register is free. The sustained rate is one item
// per cycle while the consumer takes every result. The throughput is set by
// the single output register: when the consumer stalls, the result waits
// there, and the input register can still take one further item before the
// block stops accepting. Unknown operations give an all-ones result with
// operation code zero and no overflow. Shifts take their amount from bits 10
// to 6 of operand b, and immediate logic operations zero-extend its low half.
`default_nettype none

`include "assert_macros.svh"

module mips_alu_with_decode (
    input  wire            clk,
    input  wire            rst_n,
    malu_req_if.sink       alu_in,
    malu_rsp_if.source     alu_out
);

    // Input register stage.
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    malu_pkg::opcode_t    s1_opcode_reg;
    malu_pkg::funct_t     s1_funct_reg;
    malu_pkg::word_t      s1_a_reg;
    malu_pkg::word_t      s1_b_reg;

    // Output register stage.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    malu_pkg::word_t      out_result_reg;
    logic                 out_overflow_reg;
    malu_pkg::alu_op_t    out_op_reg;

    // Single-pass decode and execute outputs.
    malu_pkg::alu_op_t    dec_op;
    malu_pkg::word_t      exec_result;
    logic                 exec_overflow;

    logic                 in_take;
    logic                 out_load;
    logic                 out_free;

    // The output register can be loaded when it is empty or being drained.
    assign out_free = !out_valid_reg || alu_out.ready;
    assign out_load = s1_valid_reg && out_free;
    assign alu_in.ready = !s1_valid_reg || out_free;
    assign in_take  = alu_in.valid && alu_in.ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !out_free);
    assign out_valid_next = out_load || (out_valid_reg && !alu_out.ready);

    malu_decode u_decode (
        .opcode (s1_opcode_reg),
        .funct  (s1_funct_reg),
        .alu_op (dec_op)
    );

    malu_exec u_exec (
        .alu_op    (dec_op),
        .operand_a (s1_a_reg),
        .operand_b (s1_b_reg),
        .result    (exec_result),
        .overflow  (exec_overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; they are qualified by the valid bits.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg <= alu_in.opcode;
            s1_funct_reg  <= alu_in.funct;
            s1_a_reg      <= alu_in.operand_a;
            s1_b_reg      <= alu_in.operand_b;
        end
        if (out_load)
        begin
            out_result_reg   <= exec_result;
            out_overflow_reg <= exec_overflow;
            out_op_reg       <= dec_op;
        end
    end

    assign alu_out.valid         = out_valid_reg;
    assign alu_out.result        = out_result_reg;
    assign alu_out.overflow      = out_overflow_reg;
    assign alu_out.alu_operation = out_op_reg;

    // Overflow may only ever be reported for an add or a subtract.
    `ASSERT_IMPLIES(a_ovf_only_arith, clk, rst_n,
        out_valid_reg && out_overflow_reg,
        out_op_reg == malu_pkg::ALU_ADD || out_op_reg == malu_pkg::ALU_SUB,
        "overflow flagged for a non-arithmetic operation")

    // An unknown operation must give an all-ones result.
    `ASSERT_IMPLIES(a_none_all_ones, clk, rst_n,
        out_valid_reg && out_op_reg == malu_pkg::ALU_NONE,
        out_result_reg == '1 && !out_overflow_reg,
        "unknown operation did not give all ones")

    // A held item in the input register must not be lost while the output stalls.
    `ASSERT_NEXT(a_s1_held, clk, rst_n,
        s1_valid_reg && !out_free,
        s1_valid_reg && $stable(s1_a_reg) && $stable(s1_b_reg),
        "input register item lost during a stall")

endmodule

`default_nettype wire

// ----- rtl/malu_decode.sv -----
// ----------------------------------------------------------------------------
// MIPS ALU operation decoder
// Maps opcode and funct fields to one ALU operation code.
// ----------------------------------------------------------------------------
`default_nettype none

module malu_decode (
    input  malu_pkg::opcode_t opcode,
    input  malu_pkg::funct_t  funct,
    output malu_pkg::alu_op_t alu_op
);

    malu_pkg::alu_op_t rtype_op;

    always_comb
    begin
        unique case (funct)
            malu_pkg::FN_ADD:  rtype_op = malu_pkg::ALU_ADD;
            malu_pkg::FN_SUB:  rtype_op = malu_pkg::ALU_SUB;
            malu_pkg::FN_AND:  rtype_op = malu_pkg::ALU_AND;
            malu_pkg::FN_OR:   rtype_op = malu_pkg::ALU_OR;
            malu_pkg::FN_XOR:  rtype_op = malu_pkg::ALU_XOR;
            malu_pkg::FN_NOR:  rtype_op = malu_pkg::ALU_NOR;
            malu_pkg::FN_NAND: rtype_op = malu_pkg::ALU_NAND;
            malu_pkg::FN_SLT:  rtype_op = malu_pkg::ALU_SLT;
            malu_pkg::FN_SLL:  rtype_op = malu_pkg::ALU_SLL;
            malu_pkg::FN_SRL:  rtype_op = malu_pkg::ALU_SRL;
            malu_pkg::FN_SRA:  rtype_op = malu_pkg::ALU_SRA;
            default:           rtype_op = malu_pkg::ALU_NONE;
        endcase
    end

    always_comb
    begin
        unique case (opcode) inside
            // Loads, stores and addi all compute an address or sum.
            malu_pkg::OPC_ADDI, malu_pkg::OPC_LB, malu_pkg::OPC_LH,
            malu_pkg::OPC_LW, malu_pkg::OPC_LBU, malu_pkg::OPC_LHU,
            malu_pkg::OPC_SB, malu_pkg::OPC_SH, malu_pkg::OPC_SW:
                alu_op = malu_pkg::ALU_ADD;
            malu_pkg::OPC_RTYPE: alu_op = rtype_op;
            malu_pkg::OPC_LUI:   alu_op = malu_pkg::ALU_LUI;
            malu_pkg::OPC_ANDI:  alu_op = malu_pkg::ALU_ANDI;
            malu_pkg::OPC_ORI:   alu_op = malu_pkg::ALU_ORI;
            malu_pkg::OPC_NORI:  alu_op = malu_pkg::ALU_NORI;
            malu_pkg::OPC_SLTI:  alu_op = malu_pkg::ALU_SLT;
            default:             alu_op = malu_pkg::ALU_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/malu_exec.sv -----
// ----------------------------------------------------------------------------
// MIPS ALU datapath
// Computes the result and the signed overflow flag for one decoded operation.
// ----------------------------------------------------------------------------
`default_nettype none

module malu_exec (
    input  malu_pkg::alu_op_t alu_op,
    input  malu_pkg::word_t   operand_a,
    input  malu_pkg::word_t   operand_b,
    output malu_pkg::word_t   result,
    output logic              overflow
);

    logic [malu_pkg::DATA_W-1:0]  a_u;
    logic [malu_pkg::DATA_W-1:0]  b_u;
    logic [malu_pkg::DATA_W-1:0]  sum;
    logic [malu_pkg::DATA_W-1:0]  diff;
    logic [malu_pkg::SHAMT_W-1:0] shamt;
    logic [malu_pkg::DATA_W-1:0]  imm_zx;
    logic                         lt;

    assign a_u    = operand_a;
    assign b_u    = operand_b;
    assign sum    = a_u + b_u;
    assign diff   = a_u - b_u;
    assign shamt  = b_u[malu_pkg::SHAMT_LSB +: malu_pkg::SHAMT_W];
    assign imm_zx = {{(malu_pkg::DATA_W-malu_pkg::IMM_W){1'b0}}, b_u[malu_pkg::IMM_W-1:0]};
    assign lt     = (operand_a < operand_b);

    always_comb
    begin
        overflow = 1'b0;
        case (alu_op)
            malu_pkg::ALU_ADD:
            begin
                result   = sum;
                overflow = ~(a_u[malu_pkg::DATA_W-1] ^ b_u[malu_pkg::DATA_W-1])
                         & (a_u[malu_pkg::DATA_W-1] ^ sum[malu_pkg::DATA_W-1]);
            end
            malu_pkg::ALU_SUB:
            begin
                result   = diff;
                overflow = (a_u[malu_pkg::DATA_W-1] ^ b_u[malu_pkg::DATA_W-1])
                         & (a_u[malu_pkg::DATA_W-1] ^ diff[malu_pkg::DATA_W-1]);
            end
            malu_pkg::ALU_AND:  result = a_u & b_u;
            malu_pkg::ALU_OR:   result = a_u | b_u;
            malu_pkg::ALU_XOR:  result = a_u ^ b_u;
            malu_pkg::ALU_NOR:  result = ~(a_u | b_u);
            malu_pkg::ALU_NAND: result = ~(a_u & b_u);
            malu_pkg::ALU_SLT:  result = {{(malu_pkg::DATA_W-1){1'b0}}, lt};
            malu_pkg::ALU_SLL:  result = a_u << shamt;
            malu_pkg::ALU_SRL:  result = a_u >> shamt;
            malu_pkg::ALU_SRA:  result = operand_a >>> shamt;
            malu_pkg::ALU_LUI:
                result = {b_u[malu_pkg::IMM_W-1:0], {(malu_pkg::DATA_W-malu_pkg::IMM_W){1'b0}}};
            malu_pkg::ALU_ANDI: result = a_u & imm_zx;
            malu_pkg::ALU_ORI:  result = a_u | imm_zx;
            malu_pkg::ALU_NORI: result = ~(a_u | imm_zx);
            default:            result = '1;
        endcase
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// MIPS ALU with decode: testbench
// Drives instruction items through the valid/ready request channel, predicts
// each result from the opcode, funct and operands, and checks every result
// item in order against its prediction under random and sustained stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // One instruction item as it is offered on the request channel.
    typedef struct packed {
        malu_pkg::opcode_t opcode;
        malu_pkg::funct_t  funct;
        malu_pkg::word_t   operand_a;
        malu_pkg::word_t   operand_b;
    } alu_instr_t;

    // One predicted result item.
    typedef struct packed {
        malu_pkg::word_t   result;
        logic              overflow;
        malu_pkg::alu_op_t op;
    } alu_result_t;

    localparam malu_pkg::word_t   WORD_MIN       = 32'sh8000_0000;
    localparam malu_pkg::word_t   WORD_MAX       = 32'sh7FFF_FFFF;
    localparam malu_pkg::word_t   WORD_ONES      = -32'sd1;
    localparam malu_pkg::opcode_t OPC_UNUSED     = 6'h3F;
    localparam malu_pkg::funct_t  FN_UNUSED      = 6'h3F;
    localparam int                MAX_GAP        = 10;
    localparam int                HOLDOFF_CYCLES = 150;
    localparam int                DRAIN_CYCLES   = 10;
    localparam int                CYCLE_LIMIT    = 200000;
    localparam int                REPORT_LIMIT   = 10;

    logic clk;
    logic rst_n;

    malu_req_if req ();
    malu_rsp_if rsp ();

    mips_alu_with_decode DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .alu_in  (req),
        .alu_out (rsp)
    );

    // Instructions waiting to be offered, and results predicted for items the
    // block has already accepted, oldest first.
    alu_instr_t  instr_queue [$];
    alu_result_t predicted_results [$];

    // Idling controls, set by the stimulus process between phases, and the hold-off count.
    bit tx_idle;
    bit rx_idle;
    bit holdoff_start;
    int holdoff_left;

    int tx_wait;
    int rx_wait;
    int items_sent;
    int results_checked;
    int mismatch_count;
    int overflow_count;
    int cycle_count;
    int op_seen [16];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Works out the decoded operation, the result word and the overflow flag
    // for one instruction. Shift amounts come from bits 10 to 6 of operand b,
    // and the immediate logic operations use its low half zero-extended.
    function automatic alu_result_t compute_alu(alu_instr_t ins);
        alu_result_t       res;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       r;
        logic [31:0]       imm;
        logic [4:0]        shamt;
        malu_pkg::alu_op_t op;
        a     = ins.operand_a;
        b     = ins.operand_b;
        imm   = {16'h0000, b[15:0]};
        shamt = b[10:6];
        case (ins.opcode)
            malu_pkg::OPC_ADDI, malu_pkg::OPC_LB, malu_pkg::OPC_LH,
            malu_pkg::OPC_LW, malu_pkg::OPC_LBU, malu_pkg::OPC_LHU,
            malu_pkg::OPC_SB, malu_pkg::OPC_SH, malu_pkg::OPC_SW:
                op = malu_pkg::ALU_ADD;
            malu_pkg::OPC_RTYPE:
            begin
                case (ins.funct)
                    malu_pkg::FN_ADD:  op = malu_pkg::ALU_ADD;
                    malu_pkg::FN_SUB:  op = malu_pkg::ALU_SUB;
                    malu_pkg::FN_AND:  op = malu_pkg::ALU_AND;
                    malu_pkg::FN_OR:   op = malu_pkg::ALU_OR;
                    malu_pkg::FN_XOR:  op = malu_pkg::ALU_XOR;
                    malu_pkg::FN_NOR:  op = malu_pkg::ALU_NOR;
                    malu_pkg::FN_NAND: op = malu_pkg::ALU_NAND;
                    malu_pkg::FN_SLT:  op = malu_pkg::ALU_SLT;
                    malu_pkg::FN_SLL:  op = malu_pkg::ALU_SLL;
                    malu_pkg::FN_SRL:  op = malu_pkg::ALU_SRL;
                    malu_pkg::FN_SRA:  op = malu_pkg::ALU_SRA;
                    default:           op = malu_pkg::ALU_NONE;
                endcase
            end
            malu_pkg::OPC_LUI:  op = malu_pkg::ALU_LUI;
            malu_pkg::OPC_ANDI: op = malu_pkg::ALU_ANDI;
            malu_pkg::OPC_ORI:  op = malu_pkg::ALU_ORI;
            malu_pkg::OPC_NORI: op = malu_pkg::ALU_NORI;
            malu_pkg::OPC_SLTI: op = malu_pkg::ALU_SLT;
            default:            op = malu_pkg::ALU_NONE;
        endcase
        res.overflow = 1'b0;
        case (op)
            malu_pkg::ALU_ADD:
            begin
                r = a + b;
                res.overflow = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
            end
            malu_pkg::ALU_SUB:
            begin
                // Operands of differing sign and a result whose sign differs from a: this
                // also flags subtracting the most negative word from a non-negative a.
                r = a - b;
                res.overflow = (a[31] ^ b[31]) & (a[31] ^ r[31]);
            end
            malu_pkg::ALU_AND:  r = a & b;
            malu_pkg::ALU_OR:   r = a | b;
            malu_pkg::ALU_XOR:  r = a ^ b;
            malu_pkg::ALU_NOR:  r = ~(a | b);
            malu_pkg::ALU_NAND: r = ~(a & b);
            malu_pkg::ALU_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            malu_pkg::ALU_SLL:  r = a << shamt;
            malu_pkg::ALU_SRL:  r = a >> shamt;
            malu_pkg::ALU_SRA:  r = $signed(a) >>> shamt;
            malu_pkg::ALU_LUI:  r = {b[15:0], 16'h0000};
            malu_pkg::ALU_ANDI: r = a & imm;
            malu_pkg::ALU_ORI:  r = a | imm;
            malu_pkg::ALU_NORI: r = ~(a | imm);
            default:            r = '1;
        endcase
        res.result = r;
        res.op     = op;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int draw_gap(bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Operands lean towards the corner values, and small values make sure the
    // shift amount field sees every pattern often.
    function automatic malu_pkg::word_t pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'sd1;
            2:       return WORD_ONES;
            3:       return WORD_MIN;
            4:       return WORD_MAX;
            5:       return malu_pkg::word_t'($urandom_range(0, 2047));
            default: return malu_pkg::word_t'($urandom);
        endcase
    endfunction

    function automatic malu_pkg::funct_t pick_rtype_funct();
        case ($urandom_range(0, 10))
            0:       return malu_pkg::FN_ADD;
            1:       return malu_pkg::FN_SUB;
            2:       return malu_pkg::FN_AND;
            3:       return malu_pkg::FN_OR;
            4:       return malu_pkg::FN_XOR;
            5:       return malu_pkg::FN_NOR;
            6:       return malu_pkg::FN_NAND;
            7:       return malu_pkg::FN_SLT;
            8:       return malu_pkg::FN_SLL;
            9:       return malu_pkg::FN_SRL;
            default: return malu_pkg::FN_SRA;
        endcase
    endfunction

    function automatic malu_pkg::opcode_t pick_itype_opcode();
        case ($urandom_range(0, 13))
            0:       return malu_pkg::OPC_ADDI;
            1:       return malu_pkg::OPC_SLTI;
            2:       return malu_pkg::OPC_ANDI;
            3:       return malu_pkg::OPC_ORI;
            4:       return malu_pkg::OPC_NORI;
            5:       return malu_pkg::OPC_LUI;
            6:       return malu_pkg::OPC_LB;
            7:       return malu_pkg::OPC_LH;
            8:       return malu_pkg::OPC_LW;
            9:       return malu_pkg::OPC_LBU;
            10:      return malu_pkg::OPC_LHU;
            11:      return malu_pkg::OPC_SB;
            12:      return malu_pkg::OPC_SH;
            default: return malu_pkg::OPC_SW;
        endcase
    endfunction

    // Mostly decodable instructions, with a share of arbitrary opcode and
    // funct pairs so that the unknown operation path and every field bit
    // are exercised.
    function automatic alu_instr_t random_instr();
        alu_instr_t ins;
        int         kind;
        kind          = $urandom_range(0, 9);
        ins.operand_a = pick_operand();
        ins.operand_b = pick_operand();
        ins.funct     = malu_pkg::funct_t'($urandom_range(0, 63));
        if (kind < 2)
            ins.opcode = malu_pkg::opcode_t'($urandom_range(0, 63));
        else if (kind < 6)
        begin
            ins.opcode = malu_pkg::OPC_RTYPE;
            if (kind != 5)
                ins.funct = pick_rtype_funct();
        end
        else
            ins.opcode = pick_itype_opcode();
        return ins;
    endfunction

    task automatic queue_instr(malu_pkg::opcode_t opc, malu_pkg::funct_t fn,
                               malu_pkg::word_t a, malu_pkg::word_t b);
        instr_queue.push_back(alu_instr_t'{opc, fn, a, b});
    endtask

    task automatic queue_random(int count);
        repeat (count) instr_queue.push_back(random_instr());
    endtask

    // Returns once every queued item has been accepted and every predicted
    // result has been seen. Sampling on the falling edge keeps it clear of
    // the clocked processes.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (instr_queue.size() != 0 || req.valid || predicted_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued instructions and records a prediction for each
    // item at the edge where the block accepts it. After an item is taken the
    // driver waits the gap it drew before offering the next one.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : instr_driver
        alu_instr_t  nxt;
        alu_result_t res;
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.opcode    <= '0;
            req.funct     <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
            tx_wait       <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                res = compute_alu(alu_instr_t'{req.opcode, req.funct,
                                               req.operand_a, req.operand_b});
                predicted_results.push_back(res);
                op_seen[res.op]++;
                if (res.overflow)
                    overflow_count++;
                items_sent++;
            end
            // The channel is free when nothing is offered or the offer has
            // just been taken; otherwise the current item is held unchanged.
            if (!req.valid || req.ready)
            begin
                if (tx_wait != 0)
                begin
                    req.valid <= 1'b0;
                    tx_wait   <= tx_wait - 1;
                end
                else if (instr_queue.size() != 0)
                begin
                    nxt            = instr_queue.pop_front();
                    req.opcode    <= nxt.opcode;
                    req.funct     <= nxt.funct;
                    req.operand_a <= nxt.operand_a;
                    req.operand_b <= nxt.operand_b;
                    req.valid     <= 1'b1;
                    tx_wait       <= draw_gap(tx_idle);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off. A pulse on holdoff_start loads the counter, and
    // ready stays low while it runs down, so the block fills and stalls its
    // input while the driver keeps offering items.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            holdoff_left <= 0;
        else if (holdoff_start)
            holdoff_left <= HOLDOFF_CYCLES;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result items, compares each field with the oldest
    // prediction, and draws a fresh wait after every item it accepts.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        alu_result_t want;
        int          w;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            w = rx_wait;
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("[%0t] unexpected result item: result=%h ovf=%b op=%0d",
                                 $time, rsp.result, rsp.overflow, rsp.alu_operation);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (rsp.result !== want.result || rsp.overflow !== want.overflow
                        || rsp.alu_operation !== want.op)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("[%0t] item %0d: expected %h %b %0d, got %h %b %0d",
                                     $time, results_checked, want.result, want.overflow,
                                     want.op, rsp.result, rsp.overflow, rsp.alu_operation);
                        mismatch_count++;
                    end
                end
                results_checked++;
                w = draw_gap(rx_idle);
            end
            else if (w > 0)
                w = w - 1;
            rx_wait   <= w;
            rsp.ready <= (w == 0) && (holdoff_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int ops_covered;
        // Known levels on every input before the first clock edge.
        req.valid     = 1'b0;
        req.opcode    = '0;
        req.funct     = '0;
        req.operand_a = '0;
        req.operand_b = '0;
        rsp.ready     = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        holdoff_start = 1'b0;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items: every operation, the overflow corners of add and
        // sub including subtraction of the most negative word, the shift
        // extremes, zero-extended immediates and both unknown-operation forms.
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_ADD,  WORD_MAX,  32'sd1);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_ADD,  WORD_MIN,  WORD_MAX);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SUB,  '0,        WORD_MIN);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SUB,  WORD_ONES, WORD_MIN);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SUB,  WORD_MIN,  32'sd1);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_AND,  WORD_ONES, 32'sh5555_AAAA);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_OR,   WORD_MIN,  32'sh0000_FFFF);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_XOR,  WORD_ONES, WORD_MAX);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_NOR,  '0,        '0);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_NAND, WORD_ONES, WORD_ONES);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SLT,  WORD_MIN,  WORD_MAX);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SLT,  WORD_MAX,  WORD_MIN);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SLL,  32'sd1,    32'sh0000_07C0);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SRL,  WORD_MIN,  32'sh0000_07C0);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SRA,  WORD_MIN,  32'sh0000_07C0);
        queue_instr(malu_pkg::OPC_RTYPE, malu_pkg::FN_SRA,  WORD_MIN,  32'shFFFF_F83F);
        queue_instr(malu_pkg::OPC_LUI,   malu_pkg::FN_SLL,  WORD_ONES, 32'sh0000_FFFF);
        queue_instr(malu_pkg::OPC_ANDI,  malu_pkg::FN_SLL,  WORD_ONES, WORD_ONES);
        queue_instr(malu_pkg::OPC_ORI,   malu_pkg::FN_SLL,  '0,        32'shFFFF_8000);
        queue_instr(malu_pkg::OPC_NORI,  malu_pkg::FN_SLL,  '0,        WORD_ONES);
        queue_instr(malu_pkg::OPC_SLTI,  malu_pkg::FN_SLL,  WORD_ONES, '0);
        queue_instr(malu_pkg::OPC_ADDI,  malu_pkg::FN_SLL,  WORD_MAX,  WORD_MAX);
        queue_instr(malu_pkg::OPC_LW,    malu_pkg::FN_SLL,  WORD_MIN,  WORD_MIN);
        queue_instr(OPC_UNUSED,          malu_pkg::FN_ADD,  WORD_MAX,  32'sd1);
        queue_instr(malu_pkg::OPC_RTYPE, FN_UNUSED,         WORD_MIN,  WORD_ONES);
        // The sender pauses here until every directed result has come back.
        wait_drained();

        // Random gaps on both sides.
        queue_random(300);
        wait_drained();

        // A stretch with no idling at all, one item per cycle.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        queue_random(200);
        wait_drained();

        // The receiver holds off for a long time while the sender keeps
        // offering back to back, so the block fills up and refuses input.
        queue_random(100);
        holdoff_start = 1'b1;
        @(negedge clk);
        holdoff_start = 1'b0;
        wait_drained();

        // Random gaps again to finish.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        queue_random(325);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        ops_covered = 0;
        foreach (op_seen[i])
            if (op_seen[i] != 0)
                ops_covered++;
        $display("Run covered %0d items over %0d of 16 operation codes, %0d of them overflowing.",
                 items_sent, ops_covered, overflow_count);
        $display("Checked %0d results under random gaps, back-to-back bursts and a %0d-cycle stall.",
                 results_checked, HOLDOFF_CYCLES);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: stops a run that hangs and reports it as a mismatch.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, predicted_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
